// File: hw/rtl/wmfrgb_pkg.sv
// Shared types and constants for the windowed RGB median filter.
package wmfrgb_pkg;

  localparam int RADIUS_DEF    = 1;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;

  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_ADDR_W   = 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int OUT_X_W    = 11;
  localparam int OUT_Y_W    = 12;
  localparam int CH_W       = 8;
  localparam int N_CH       = 3;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  typedef logic [CH_W-1:0] chan_t;

  // red sits in the low byte, as on the stream
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  localparam chan_t BORDER_RED   = 8'd0;
  localparam chan_t BORDER_GREEN = 8'd255;
  localparam chan_t BORDER_BLUE  = 8'd0;

endpackage

// File: hw/rtl/windowed_median_filter_rgb_top.sv
// Windowed RGB median filter: line memory, sliding window, rank-based median.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata: red, green, blue; tuser: frame_start
//  out_    | out | out_tvalid/out_tready| tdata: x, y, red, green, blue; tlast: run_last
//  cfg_    | in  | cfg_we               | cfg_addr selects width/height, cfg_wdata
//
// One pixel request per clock while no stage stalls. A pixel that yields both an
// interior and a border result holds the output stage until both have gone out.
// After its input request is accepted, a result passes these registers in order: the
// request is registered with the line memory read, then window shift, rank compare and
// median select into the output register. The line memory port (one read,
// one write per cycle) sets the pace.
// Synchronous active-low reset clears counters and valids, loads config reset
// values; line memory and window are not cleared and hold data only once written.
// Stalls propagate back stage by stage, so empty stages keep taking pixels
// while a result waits at the output.
module windowed_median_filter_rgb_top
  import wmfrgb_pkg::*;
#(
  parameter int RADIUS    = RADIUS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic                  in_tuser,   // [0] frame_start
  // filtered results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [10:0] x, [22:11] y, [30:23] red,
                                            // [38:31] green, [46:39] blue, [47] zero
  output logic                  out_tlast,  // run_last
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SIDE = 2 * RADIUS + 1;
  localparam int WIN  = SIDE * SIDE;
  localparam int MID  = WIN / 2;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int CW   = (XW + 1 > WIDTH_REG_W) ? XW + 1 : WIDTH_REG_W;
  localparam int HW   = HEIGHT_REG_W;
  localparam int YW   = OUT_Y_W;
  localparam int RW   = $clog2(WIN);

  // one line memory word: the 2*RADIUS pixels above, oldest row in slot 0
  typedef pixel_t [2*RADIUS-1:0] line_word_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
      endcase
    end
  end

  // effective size, clamped to what the datapath supports
  logic [CW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  always_comb begin
    eff_w = CW'(width_r);
    if (eff_w == '0)
      eff_w = CW'(1);
    else if (eff_w > CW'(MAX_WIDTH))
      eff_w = CW'(MAX_WIDTH);
    eff_h = height_r;
    if (eff_h == '0)
      eff_h = HW'(1);
    else if (eff_h > HW'(MAX_HEIGHT))
      eff_h = HW'(MAX_HEIGHT);
  end

  // ---------------------------------------------------------------------------
  // stage handshake: each stage loads when empty or when it drains
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic s4_int_r, s4_bord_r;
  logic s4_last;
  logic in_acc;
  logic out_acc;

  assign s4_last = !(s4_int_r && s4_bord_r);
  assign out_acc = s4_v_r && out_tready;
  assign rdy4    = !s4_v_r || (out_tready && s4_last);
  assign rdy3    = !s3_v_r || rdy4;
  assign rdy2    = !s2_v_r || rdy3;
  assign rdy1    = !s1_v_r || rdy2;

  assign in_tready = rdy1;
  assign in_acc    = in_tvalid && rdy1;

  // ---------------------------------------------------------------------------
  // stage 0: position of the incoming pixel, line memory read issue
  // ---------------------------------------------------------------------------
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [XW-1:0] x0;
  logic [YW-1:0] y0;
  logic          int0, bord0;
  logic [CW-1:0] xn;
  logic [HW-1:0] yn;

  always_comb begin
    x0 = col_r;
    y0 = row_r;
    if (in_tuser || CW'(col_r) >= eff_w)
      x0 = '0;
    if (in_tuser || HW'(row_r) >= eff_h)
      y0 = '0;

    int0  = (x0 >= XW'(2 * RADIUS)) && (y0 >= YW'(2 * RADIUS));
    bord0 = (x0 < XW'(RADIUS)) || (CW'(x0) + CW'(RADIUS + 1) > eff_w) ||
            (y0 < YW'(RADIUS)) || (HW'(y0) + HW'(RADIUS + 1) > eff_h);

    xn      = CW'(x0) + CW'(1);
    yn      = HW'(y0) + HW'(1);
    col_nxt = XW'(xn);
    row_nxt = y0;
    if (xn >= eff_w) begin
      col_nxt = '0;
      row_nxt = (yn >= eff_h) ? '0 : YW'(yn);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // line memory: column-wise, one read and one write per cycle
  // ---------------------------------------------------------------------------
  line_word_t    line_mem [MAX_WIDTH];
  line_word_t    rd_r;
  line_word_t    fwd_pix_r;
  logic          fwd_r;
  line_word_t    mem_wdata;
  logic          mem_we;

  logic [XW-1:0] s1_x_r;
  logic [YW-1:0] s1_y_r;
  logic          s1_int_r, s1_bord_r;
  pixel_t        s1_pix_r;

  assign mem_we = s1_v_r && rdy2;

  always_ff @(posedge clk) begin
    if (mem_we)
      line_mem[s1_x_r] <= mem_wdata;
    if (in_acc) begin
      rd_r      <= line_mem[x0];
      // same column written on this edge (single-column image): bypass
      fwd_r     <= mem_we && (s1_x_r == x0);
      fwd_pix_r <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      s1_v_r <= 1'b0;
    else if (rdy1)
      s1_v_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r    <= x0;
      s1_y_r    <= y0;
      s1_int_r  <= int0;
      s1_bord_r <= bord0;
      s1_pix_r  <= pixel_t'(in_tdata);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: assemble the column, write it back shifted up, slide window
  // ---------------------------------------------------------------------------
  line_word_t above;
  pixel_t     col_pix [SIDE];

  always_comb begin
    above = fwd_r ? fwd_pix_r : rd_r;
    for (int k = 0; k < 2 * RADIUS; k++)
      col_pix[k] = above[k];
    col_pix[2*RADIUS] = s1_pix_r;
    for (int k = 0; k < 2 * RADIUS; k++)
      mem_wdata[k] = col_pix[k+1];
  end

  // window: win_r[dx][dy], dx = 0 is the oldest column
  pixel_t        win_r [SIDE][SIDE];
  logic [XW-1:0] s2_x_r;
  logic [YW-1:0] s2_y_r;
  logic          s2_int_r, s2_bord_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      s2_v_r <= 1'b0;
    else if (rdy2)
      s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int dx = 0; dx < SIDE - 1; dx++)
        win_r[dx] <= win_r[dx+1];
      for (int dy = 0; dy < SIDE; dy++)
        win_r[SIDE-1][dy] <= col_pix[dy];
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_int_r  <= s1_int_r;
      s2_bord_r <= s1_bord_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: rank of every window entry per channel (ties broken by position)
  // ---------------------------------------------------------------------------
  chan_t          wv   [N_CH][WIN];
  logic [WIN-1:0] lt   [N_CH][WIN];
  logic [RW-1:0]  rank [N_CH][WIN];

  always_comb begin
    for (int c = 0; c < N_CH; c++) begin
      for (int dy = 0; dy < SIDE; dy++) begin
        for (int dx = 0; dx < SIDE; dx++)
          wv[c][dy*SIDE+dx] = win_r[dx][dy][c*CH_W +: CH_W];
      end
    end
    for (int c = 0; c < N_CH; c++) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++)
          lt[c][i][j] = (wv[c][j] < wv[c][i]) || ((wv[c][j] == wv[c][i]) && (j < i));
        rank[c][i] = RW'($countones(lt[c][i]));
      end
    end
  end

  chan_t         v3_r    [N_CH][WIN];
  logic [RW-1:0] rank3_r [N_CH][WIN];
  logic [XW-1:0] s3_x_r;
  logic [YW-1:0] s3_y_r;
  logic          s3_int_r, s3_bord_r;

  always_ff @(posedge clk) begin
    if (!rst_n)
      s3_v_r <= 1'b0;
    else if (rdy3)
      s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      v3_r      <= wv;
      rank3_r   <= rank;
      s3_x_r    <= s2_x_r;
      s3_y_r    <= s2_y_r;
      s3_int_r  <= s2_int_r;
      s3_bord_r <= s2_bord_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: pick the entry of middle rank; ranks form a permutation
  // ---------------------------------------------------------------------------
  chan_t med [N_CH];

  always_comb begin
    for (int c = 0; c < N_CH; c++) begin
      med[c] = '0;
      for (int i = 0; i < WIN; i++)
        med[c] = med[c] | ((rank3_r[c][i] == RW'(MID)) ? v3_r[c][i] : '0);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: output register, up to two results per pixel
  // ---------------------------------------------------------------------------
  chan_t         s4_med_r [N_CH];
  logic [XW-1:0] s4_x_r;
  logic [YW-1:0] s4_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r    <= 1'b0;
      s4_int_r  <= 1'b0;
      s4_bord_r <= 1'b0;
    end else if (rdy4) begin
      // pixels with no result are dropped here
      s4_v_r    <= s3_v_r && (s3_int_r || s3_bord_r);
      s4_int_r  <= s3_v_r && s3_int_r;
      s4_bord_r <= s3_v_r && s3_bord_r;
    end else if (out_acc) begin
      // interior went out first, border still pending
      s4_int_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      s4_med_r <= med;
      s4_x_r   <= s3_x_r;
      s4_y_r   <= s3_y_r;
    end
  end

  logic [XW-1:0] ox;
  logic [YW-1:0] oy;
  chan_t         o_red, o_green, o_blue;

  always_comb begin
    if (s4_int_r) begin
      ox      = s4_x_r - XW'(RADIUS);
      oy      = s4_y_r - YW'(RADIUS);
      o_red   = s4_med_r[0];
      o_green = s4_med_r[1];
      o_blue  = s4_med_r[2];
    end else begin
      ox      = s4_x_r;
      oy      = s4_y_r;
      o_red   = BORDER_RED;
      o_green = BORDER_GREEN;
      o_blue  = BORDER_BLUE;
    end
  end

  assign out_tvalid = s4_v_r;
  assign out_tlast  = s4_last;
  assign out_tdata  = {1'b0, o_blue, o_green, o_red, oy, OUT_X_W'(ox)};

`ifndef NO_ASSERTIONS
  // a held result always has something to send
  a_out_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r |-> (s4_int_r || s4_bord_r))
    else $error("output stage valid with no pending result");

  // interior centers come only from pixels far enough into the frame
  a_int_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && s4_int_r) |-> (s4_x_r >= XW'(2 * RADIUS) && s4_y_r >= YW'(2 * RADIUS)))
    else $error("interior result from an edge pixel");

  // an accepted pixel occupies the memory read stage on the next cycle
  a_acc_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted pixel lost before line memory stage");

  // a two-result pixel keeps the output stage after its first result
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && !s4_last) |=> (s4_v_r && s4_bord_r && !s4_int_r))
    else $error("border result lost after interior result");
`endif

endmodule

// File: test/windowed_median_filter_rgb_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the windowed RGB median filter top level.
module windowed_median_filter_rgb_top_tb;
  import wmfrgb_pkg::*;

  localparam int RAD          = RADIUS_DEF;
  localparam int SIDE         = 2 * RAD + 1;
  localparam int WIN_N        = SIDE * SIDE;
  localparam int MAX_W        = MAX_WIDTH_DEF;
  localparam int IDLE_PCT     = 23;       // idle cycles per hundred, each side
  localparam int TAIL_CYCLES  = 16;       // pipeline is four deep, two-result pixels hold it
  localparam int LIMIT_CYCLES = 2000000;  // hard stop for a hung run
  localparam int MAX_SHOWN    = 10;
  localparam int RANDOM_ITEMS = 1700;

  // out_tdata field offsets, lowest first
  localparam int X_LSB = 0;
  localparam int Y_LSB = X_LSB + OUT_X_W;
  localparam int R_LSB = Y_LSB + OUT_Y_W;
  localparam int G_LSB = R_LSB + CH_W;
  localparam int B_LSB = G_LSB + CH_W;
  localparam int PAD_LSB = B_LSB + CH_W;

  typedef struct {
    logic [OUT_X_W-1:0] x;
    logic [OUT_Y_W-1:0] y;
    pixel_t             rgb;
    logic               last;
  } filt_pix_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the filter: geometry registers, position and line memory.
  logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
  int unsigned             col_pos    = 0;
  int unsigned             row_pos    = 0;
  pixel_t                  line_mem [SIDE][MAX_W];
  pixel_t                  window_px [WIN_N];

  filt_pix_t pending_pixels [$];  // filtered pixels still owed by the block
  int        bad_results = 0;
  bit        steady = 1'b0;       // when set, neither side idles

  windowed_median_filter_rgb_top #(
    .RADIUS   (RAD),
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the block hangs.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[windowed_median_filter_rgb_top] ERROR");
    $finish;
  end

  // Result side back-pressure: random stalls unless a steady stretch is on.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Rank-based median of one channel (0 red, 1 green, 2 blue) over window_px.
  function automatic chan_t channel_median(input int ch);
    chan_t v [WIN_N];
    chan_t med;
    int    i, j, lt, eq;
    med = '0;
    for (i = 0; i < WIN_N; i++) v[i] = window_px[i][ch*CH_W +: CH_W];
    for (i = 0; i < WIN_N; i++) begin
      lt = 0;
      eq = 0;
      for (j = 0; j < WIN_N; j++) begin
        if (v[j] < v[i]) lt++;
        else if (v[j] == v[i]) eq++;
      end
      // v[i] is the median if the middle rank falls in its run of equals
      if (lt <= WIN_N / 2 && lt + eq > WIN_N / 2) med = v[i];
    end
    return med;
  endfunction

  // Place one accepted pixel and queue the filtered pixels it releases:
  // the interior centre first, then the pixel itself if it lies on the border.
  task automatic filter_pixel(input logic fs, input pixel_t px);
    int unsigned w, h, x, y;
    int          dy, dx;
    bit          inner, on_border;
    filt_pix_t   r;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_W) ? MAX_W : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // counters left past a shrunk geometry restart at zero
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    x = col_pos;
    y = row_pos;
    line_mem[y % SIDE][x] = px;
    inner     = (x >= 2 * RAD) && (y >= 2 * RAD);
    on_border = (x < RAD) || (x + RAD + 1 > w) || (y < RAD) || (y + RAD + 1 > h);
    if (inner) begin
      for (dy = 0; dy < SIDE; dy++)
        for (dx = 0; dx < SIDE; dx++)
          window_px[dy*SIDE + dx] = line_mem[(y - 2*RAD + dy) % SIDE][x - 2*RAD + dx];
      r.x         = OUT_X_W'(x - RAD);
      r.y         = OUT_Y_W'(y - RAD);
      r.rgb.red   = channel_median(0);
      r.rgb.green = channel_median(1);
      r.rgb.blue  = channel_median(2);
      r.last      = !on_border;
      pending_pixels = {pending_pixels, r};
    end
    if (on_border) begin
      r.x         = OUT_X_W'(x);
      r.y         = OUT_Y_W'(y);
      r.rgb.red   = BORDER_RED;
      r.rgb.green = BORDER_GREEN;
      r.rgb.blue  = BORDER_BLUE;
      r.last      = 1'b1;
      pending_pixels = {pending_pixels, r};
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // Result checker: every accepted output against the oldest owed pixel.
  always @(posedge clk) begin : result_check
    filt_pix_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_SHOWN)
          $display("unexpected result: x=%0d y=%0d rgb=%02h/%02h/%02h last=%0b",
                   out_tdata[X_LSB +: OUT_X_W], out_tdata[Y_LSB +: OUT_Y_W],
                   out_tdata[R_LSB +: CH_W], out_tdata[G_LSB +: CH_W],
                   out_tdata[B_LSB +: CH_W], out_tlast);
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata[X_LSB +: OUT_X_W] !== want.x ||
            out_tdata[Y_LSB +: OUT_Y_W] !== want.y ||
            out_tdata[R_LSB +: CH_W] !== want.rgb.red ||
            out_tdata[G_LSB +: CH_W] !== want.rgb.green ||
            out_tdata[B_LSB +: CH_W] !== want.rgb.blue ||
            out_tdata[PAD_LSB] !== 1'b0 ||
            out_tlast !== want.last) begin
          bad_results++;
          if (bad_results <= MAX_SHOWN) begin
            $display("mismatch: exp x=%0d y=%0d rgb=%02h/%02h/%02h last=%0b",
                     want.x, want.y, want.rgb.red, want.rgb.green, want.rgb.blue,
                     want.last);
            $display("          got x=%0d y=%0d rgb=%02h/%02h/%02h last=%0b pad=%0b",
                     out_tdata[X_LSB +: OUT_X_W], out_tdata[Y_LSB +: OUT_Y_W],
                     out_tdata[R_LSB +: CH_W], out_tdata[G_LSB +: CH_W],
                     out_tdata[B_LSB +: CH_W], out_tlast, out_tdata[PAD_LSB]);
          end
        end
      end
    end
  end

  // Mostly random channel values, with the extremes over-weighted.
  function automatic pixel_t random_pixel();
    pixel_t p;
    int     c;
    for (c = 0; c < N_CH; c++) begin
      case ($urandom_range(7))
        0:       p[c*CH_W +: CH_W] = 8'h00;
        1:       p[c*CH_W +: CH_W] = 8'hFF;
        default: p[c*CH_W +: CH_W] = CH_W'($urandom_range(255));
      endcase
    end
    return p;
  endfunction

  // One pixel request; inputs move on the falling edge, accept on the rising.
  task automatic send_pixel(input logic fs, input pixel_t px);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    filter_pixel(fs, px);
  endtask

  // Stop sending and wait until every owed pixel is out and the pipe is empty.
  // Some pixels release nothing, hence the tail.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Register write; only called with the block idle.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) width_reg = val[WIDTH_REG_W-1:0];
    else height_reg = val[HEIGHT_REG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
  endtask

  // A few pixels at the reset geometry (640x480): top-left border run.
  task automatic test_reset_geometry();
    int i;
    for (i = 0; i < 3; i++) send_pixel(1'b0, random_pixel());
    drain_results();
  endtask

  // 4x4 frame: border-only, interior+border and interior-only pixels,
  // with channel values at the extremes and alternating bit patterns.
  task automatic test_corner_frame();
    chan_t  levels [4];
    pixel_t p;
    int     i;
    levels[0] = 8'h00;
    levels[1] = 8'hFF;
    levels[2] = 8'h55;
    levels[3] = 8'hAA;
    set_geometry(4, 4);
    for (i = 0; i < 16; i++) begin
      p.red   = levels[i % 4];
      p.green = levels[(i / 2) % 4];
      p.blue  = levels[(3 * i) % 4];
      send_pixel(i == 0, p);
    end
    drain_results();
  endtask

  // Zero width and height act as a 1x1 image: every pixel is border at 0,0.
  task automatic test_degenerate_size();
    int i;
    set_geometry(0, 0);
    for (i = 0; i < 3; i++) send_pixel(i == 0, random_pixel());
    drain_results();
  endtask

  // Shrink the geometry under both counters mid-frame, then carry on
  // without frame_start: position restarts at 0,0.
  task automatic test_shrink_mid_frame();
    int i;
    set_geometry(8, 8);
    for (i = 0; i < 3 * 8 + 5; i++) send_pixel(i == 0, random_pixel());
    drain_results();
    set_geometry(4, 2);
    for (i = 0; i < 12; i++) send_pixel(1'b0, random_pixel());
    drain_results();
  endtask

  // Random small geometries, whole frames with random content plus a partial
  // one, occasional stray frame_start. One phase runs with no idling and some
  // pause mid-phase until everything owed has come out.
  task automatic test_random_frames();
    int unsigned w, h, ew, eh, n, sent, phase;
    int          i;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(7) == 0) begin
        w = $urandom_range(13, 64);
        h = $urandom_range(1, 6);
      end else begin
        w = $urandom_range(0, 12);
        h = $urandom_range(0, 12);
      end
      ew = (w == 0) ? 1 : w;
      eh = (h == 0) ? 1 : h;
      set_geometry(w, h);
      steady = (phase == 4);
      n = ew * eh * $urandom_range(1, 3) + $urandom_range(0, 2 * ew);
      for (i = 0; i < n; i++) begin
        if (i == n / 2 && $urandom_range(3) == 0) drain_results();
        send_pixel(i == 0 || $urandom_range(63) == 0, random_pixel());
      end
      drain_results();
      sent += n;
      phase++;
    end
    steady = 1'b0;
  endtask

  // Two 16x6 frames back to back, the second without frame_start;
  // long stretch without idling on either side.
  task automatic test_steady_stream();
    int i;
    steady = 1'b1;
    set_geometry(16, 6);
    for (i = 0; i < 2 * 16 * 6; i++) send_pixel(i == 0, random_pixel());
    drain_results();
    steady = 1'b0;
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_corner_frame();
    test_degenerate_size();
    test_shrink_mid_frame();
    test_random_frames();
    test_steady_stream();
    drain_results();

    if (bad_results == 0 && pending_pixels.size() == 0) begin
      $display("[windowed_median_filter_rgb_top] OK");
    end else begin
      $display("[windowed_median_filter_rgb_top] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/wmfrgb_pkg.sv
hw/rtl/windowed_median_filter_rgb_top.sv
test/windowed_median_filter_rgb_top_tb.sv
